/* hw/rtl/lmps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmps_pkg
// Field widths, item codes and reset values for the LED matrix plane scanner.
// ----------------------------------------------------------------------------
package lmps_pkg;

  localparam int unsigned ModeW   = 1;
  localparam int unsigned PlaneW  = 2;
  localparam int unsigned RowW    = 4;
  localparam int unsigned ColW    = 5;
  localparam int unsigned ColourW = 6;
  localparam int unsigned SeqW    = 14;

  // item codes carried on the mode field
  localparam logic [ModeW-1:0] MODE_WRITE = 1'b0;
  localparam logic [ModeW-1:0] MODE_TICK  = 1'b1;

  // weighting order {0,1,0,2,0,1,0}, slot 0 in the lowest bits
  localparam logic [SeqW-1:0] LAYER_SEQ_RESET = 14'd1156;

  // one column word as it leaves the block
  typedef struct packed {
    logic [RowW-1:0]    row_address;
    logic [ColW-1:0]    column_index;
    logic [ColourW-1:0] data_bits;
    logic [PlaneW-1:0]  shown_plane;
    logic               latch_last;
  } word_t;

endpackage

/* hw/rtl/led_matrix_plane_scanner_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_plane_scanner_unit
// Bit-plane refresh engine for an LED matrix: stores colour words per plane,
// row and column, and on each refresh tick scans one row of one plane out.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ---------------------------
//  in        sink       in_valid_i / in_stall_o    mode, plane, pixel_row,
//                                                  pixel_col, colour_bits
//  out       source     out_valid_o / out_stall_i  row_address, column_index,
//                                                  data_bits, shown_plane,
//                                                  latch_last
//  cfg       sink       cfg_valid_i / cfg_ready_o  layer_sequence
//
//  A tick makes one pixel store read per column, set by the single read
//  port of the store; the next input word is held off until every read of
//  the tick has returned.
//  After reset the store is swept clear, one entry a cycle, over all
//  PLANES * ROWS * COLUMNS entries (1536 at the defaults); input words are
//  held off meanwhile, configuration writes are taken as ever.
//  Output stalls hold the output register; the store read data register acts
//  as the second slot, so one word a cycle flows within a tick when the sink takes them.
// ----------------------------------------------------------------------------
module led_matrix_plane_scanner_unit #(
  parameter int unsigned ROWS            = 16,
  parameter int unsigned COLUMNS         = 32,
  parameter int unsigned PLANES          = 3,
  parameter int unsigned SEQUENCE_LENGTH = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lmps_pkg::ModeW-1:0]        mode_i,
  input  logic [lmps_pkg::PlaneW-1:0]       plane_i,
  input  logic [lmps_pkg::RowW-1:0]         pixel_row_i,
  input  logic [lmps_pkg::ColW-1:0]         pixel_col_i,
  input  logic [lmps_pkg::ColourW-1:0]      colour_bits_i,
  // column words
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lmps_pkg::RowW-1:0]         row_address_o,
  output logic [lmps_pkg::ColW-1:0]         column_index_o,
  output logic [lmps_pkg::ColourW-1:0]      data_bits_o,
  output logic [lmps_pkg::PlaneW-1:0]       shown_plane_o,
  output logic                              latch_last_o,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lmps_pkg::SeqW-1:0]         layer_sequence_i
);

  localparam int unsigned Depth = PLANES * ROWS * COLUMNS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned RowCW = $clog2(ROWS);
  localparam int unsigned ColCW = $clog2(COLUMNS);
  localparam int unsigned SlotW = (SEQUENCE_LENGTH > 1) ? $clog2(SEQUENCE_LENGTH) : 1;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [RowCW-1:0] LastRow  = RowCW'(ROWS - 1);
  localparam logic [ColCW-1:0] LastCol  = ColCW'(COLUMNS - 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(SEQUENCE_LENGTH - 1);
  localparam logic [lmps_pkg::PlaneW-1:0] TopPlane = lmps_pkg::PlaneW'(PLANES - 1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [lmps_pkg::SeqW-1:0]    layer_seq_q;
  logic                         clr_q, clr_d;
  logic [AddrW-1:0]             clr_addr_q, clr_addr_d;
  logic [SlotW-1:0]             slot_q, slot_d;
  logic [RowCW-1:0]             scan_row_q, scan_row_d;

  // current tick
  logic                         issuing_q, issuing_d;
  logic [ColCW-1:0]             col_q, col_d;
  logic [AddrW-1:0]             base_q, base_d;
  logic [RowCW-1:0]             tk_row_q, tk_row_d;
  logic [lmps_pkg::PlaneW-1:0]  tk_plane_q, tk_plane_d;

  // store read stage
  logic                         mem_valid_q, mem_valid_d;
  logic [ColCW-1:0]             mem_col_q;
  logic [lmps_pkg::ColourW-1:0] mem_rdata_q;

  // output register
  logic                         out_valid_q, out_valid_d;
  lmps_pkg::word_t              out_q;

  logic [lmps_pkg::ColourW-1:0] mem_q [Depth];

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic busy;
  logic in_take, is_tick, is_write, wr_in_range;
  logic out_take, load_out, issue;
  logic mem_we;
  logic [AddrW-1:0] mem_waddr, wr_addr, rd_addr;
  logic [lmps_pkg::ColourW-1:0] mem_wdata;
  logic [lmps_pkg::PlaneW-1:0] seq_code, sel_plane;

  // one item at a time: hold off the next word until every read has returned
  assign busy       = issuing_q | mem_valid_q;
  assign in_stall_o = clr_q | busy;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign is_tick    = in_take & (mode_i == lmps_pkg::MODE_TICK);
  assign is_write   = in_take & (mode_i == lmps_pkg::MODE_WRITE);

  assign cfg_ready_o = 1'b1;

  assign out_take = out_valid_q & ~out_stall_i;
  // move the read word on when the output register is free or being emptied
  assign load_out = mem_valid_q & (~out_valid_q | out_take);
  // read a column only when the read data register will have room
  assign issue    = issuing_q & (~mem_valid_q | load_out);

  // --------------------------------------------------------------------------
  // Plane selection and addressing
  // --------------------------------------------------------------------------
  assign wr_in_range = (32'(plane_i) < PLANES) && (32'(pixel_row_i) < ROWS) &&
                       (32'(pixel_col_i) < COLUMNS);
  assign wr_addr = AddrW'((32'(plane_i) * ROWS + 32'(pixel_row_i)) * COLUMNS +
                          32'(pixel_col_i));
  assign rd_addr = base_q + AddrW'(col_q);

  always_comb begin
    seq_code  = lmps_pkg::PlaneW'(layer_seq_q >> {slot_q, 1'b0});
    // clamp an unused code to the top plane
    sel_plane = (32'(seq_code) >= PLANES) ? TopPlane : seq_code;
  end

  // clearing pass owns the write port until it ends; input is held off then
  always_comb begin
    if (clr_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = is_write & wr_in_range;
      mem_waddr = wr_addr;
      mem_wdata = colour_bits_i;
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    clr_d       = clr_q;
    clr_addr_d  = clr_addr_q;
    slot_d      = slot_q;
    scan_row_d  = scan_row_q;
    issuing_d   = issuing_q;
    col_d       = col_q;
    base_d      = base_q;
    tk_row_d    = tk_row_q;
    tk_plane_d  = tk_plane_q;
    mem_valid_d = mem_valid_q;
    out_valid_d = out_valid_q;

    if (clr_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == LastAddr) begin
        clr_d = 1'b0;
      end
    end

    // a tick latches its plane and row, and advances both counters
    if (is_tick) begin
      slot_d     = (slot_q == LastSlot) ? '0 : slot_q + SlotW'(1);
      scan_row_d = (scan_row_q == LastRow) ? '0 : scan_row_q + RowCW'(1);
      tk_row_d   = scan_row_q;
      tk_plane_d = sel_plane;
      base_d     = AddrW'((32'(sel_plane) * ROWS + 32'(scan_row_q)) * COLUMNS);
      col_d      = '0;
      issuing_d  = 1'b1;
    end

    if (issue) begin
      col_d = col_q + ColCW'(1);
      if (col_q == LastCol) begin
        issuing_d = 1'b0;
      end
    end

    if (issue) begin
      mem_valid_d = 1'b1;
    end else if (load_out) begin
      mem_valid_d = 1'b0;
    end

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_seq_q <= lmps_pkg::LAYER_SEQ_RESET;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      slot_q      <= '0;
      scan_row_q  <= '0;
      issuing_q   <= 1'b0;
      col_q       <= '0;
      mem_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        layer_seq_q <= layer_sequence_i;
      end
      clr_q       <= clr_d;
      clr_addr_q  <= clr_addr_d;
      slot_q      <= slot_d;
      scan_row_q  <= scan_row_d;
      issuing_q   <= issuing_d;
      col_q       <= col_d;
      mem_valid_q <= mem_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    tk_row_q   <= tk_row_d;
    tk_plane_q <= tk_plane_d;
    if (issue) begin
      mem_col_q <= col_q;
    end
    if (load_out) begin
      out_q.row_address  <= lmps_pkg::RowW'(tk_row_q);
      out_q.column_index <= lmps_pkg::ColW'(mem_col_q);
      out_q.data_bits    <= mem_rdata_q;
      out_q.shown_plane  <= tk_plane_q;
      out_q.latch_last   <= (mem_col_q == LastCol);
    end
  end

  // --------------------------------------------------------------------------
  // Pixel store: one write and one registered read a cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      mem_rdata_q <= mem_q[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign out_valid_o    = out_valid_q;
  assign row_address_o  = out_q.row_address;
  assign column_index_o = out_q.column_index;
  assign data_bits_o    = out_q.data_bits;
  assign shown_plane_o  = out_q.shown_plane;
  assign latch_last_o   = out_q.latch_last;

endmodule

/* bench/led_matrix_plane_scanner_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_plane_scanner_unit_test
// Self-checking bench for the LED matrix plane scanner. A shadow pixel store
// and shadow slot and row counters predict the column words of every refresh
// tick; a monitor compares each column word taken from the block, field by
// field, with the oldest prediction. Directed words cover the clamped plane
// codes, off-plane writes, ignored tick fields and counter wrapping; random
// traffic with random gaps and output stalls follows.
// ----------------------------------------------------------------------------
module led_matrix_plane_scanner_unit_test;

  // geometry of the block under test, matching its default parameters
  localparam int NRows   = 16;
  localparam int NCols   = 32;
  localparam int NPlanes = 3;
  localparam int SeqLen  = 7;

  // cycles without any handshake before the run is abandoned; the clearing
  // sweep after reset alone covers NPlanes * NRows * NCols entries
  localparam int StallLimit   = 6000;
  // quiet time before a register write, so that a pixel write can finish
  localparam int SettleCycles = 8;
  // quiet time at the end: longer than one full tick
  localparam int TailCycles   = 2 * NCols;
  // idle chance per cycle, in percent, on either side
  localparam int IdlePct      = 27;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic [lmps_pkg::ModeW-1:0]     mode_i        = lmps_pkg::MODE_WRITE;
  logic [lmps_pkg::PlaneW-1:0]    plane_i       = '0;
  logic [lmps_pkg::RowW-1:0]      pixel_row_i   = '0;
  logic [lmps_pkg::ColW-1:0]      pixel_col_i   = '0;
  logic [lmps_pkg::ColourW-1:0]   colour_bits_i = '0;

  logic                           out_valid_o;
  logic                           out_stall_i   = 1'b0;
  logic [lmps_pkg::RowW-1:0]      row_address_o;
  logic [lmps_pkg::ColW-1:0]      column_index_o;
  logic [lmps_pkg::ColourW-1:0]   data_bits_o;
  logic [lmps_pkg::PlaneW-1:0]    shown_plane_o;
  logic                           latch_last_o;

  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [lmps_pkg::SeqW-1:0]      layer_sequence_i = '0;

  // shadow state of the scanner
  logic [lmps_pkg::ColourW-1:0] pixel_shadow [NPlanes][NRows][NCols];
  logic [lmps_pkg::SeqW-1:0]    seq_shadow = lmps_pkg::LAYER_SEQ_RESET;
  int                           next_slot  = 0;
  int                           next_row   = 0;

  // column words still owed by the block, oldest first
  lmps_pkg::word_t planned_words [$];
  lmps_pkg::word_t head_word;

  // run bookkeeping
  bit no_idle       = 1'b0;
  int failures      = 0;
  int writes_sent   = 0;
  int offplane_sent = 0;
  int ticks_sent    = 0;
  int words_checked = 0;
  int cfg_writes    = 0;
  int quiet_cycles  = 0;

  led_matrix_plane_scanner_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .plane_i         (plane_i),
    .pixel_row_i     (pixel_row_i),
    .pixel_col_i     (pixel_col_i),
    .colour_bits_i   (colour_bits_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .row_address_o   (row_address_o),
    .column_index_o  (column_index_o),
    .data_bits_o     (data_bits_o),
    .shown_plane_o   (shown_plane_o),
    .latch_last_o    (latch_last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .layer_sequence_i(layer_sequence_i)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Plane shown for a sequence slot; a code beyond the last plane shows the
  // last plane.
  function automatic logic [lmps_pkg::PlaneW-1:0] plane_for_slot(
      logic [lmps_pkg::SeqW-1:0] seq, int slot);
    logic [1:0] code;
    code = seq[2*slot +: 2];
    if (code >= NPlanes) code = 2'(NPlanes - 1);
    return code;
  endfunction

  // Queue the column words of one refresh tick and advance both counters.
  task automatic predict_column_words();
    logic [lmps_pkg::PlaneW-1:0] pl;
    int                          rw;
    lmps_pkg::word_t             w;
    pl = plane_for_slot(seq_shadow, next_slot);
    rw = next_row;
    next_slot = (next_slot + 1) % SeqLen;
    next_row  = (next_row + 1) % NRows;
    for (int c = 0; c < NCols; c++) begin
      w.row_address  = lmps_pkg::RowW'(rw);
      w.column_index = lmps_pkg::ColW'(c);
      w.data_bits    = pixel_shadow[pl][rw][c];
      w.shown_plane  = pl;
      w.latch_last   = (c == NCols - 1);
      planned_words.push_back(w);
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one word, hold it until taken, then fold it into the shadow state.
  // Gaps go in before the word is raised, never while it is offered.
  task automatic send_word(input logic [lmps_pkg::ModeW-1:0] mode,
                           input logic [lmps_pkg::PlaneW-1:0] plane,
                           input logic [lmps_pkg::RowW-1:0] row,
                           input logic [lmps_pkg::ColW-1:0] col,
                           input logic [lmps_pkg::ColourW-1:0] colour);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      @(negedge clk);
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    plane_i       <= plane;
    pixel_row_i   <= row;
    pixel_col_i   <= col;
    colour_bits_i <= colour;
    do @(posedge clk); while (in_stall_o);
    if (mode == lmps_pkg::MODE_TICK) begin
      ticks_sent++;
      predict_column_words();
    end else begin
      writes_sent++;
      // drop writes to a plane that does not exist
      if (plane < NPlanes) pixel_shadow[plane][row][col] = colour;
      else offplane_sent++;
    end
  endtask

  task automatic send_tick();
    send_word(lmps_pkg::MODE_TICK, lmps_pkg::PlaneW'($urandom_range(3)),
              lmps_pkg::RowW'($urandom_range(NRows - 1)),
              lmps_pkg::ColW'($urandom_range(NCols - 1)),
              lmps_pkg::ColourW'($urandom_range(63)));
  endtask

  // Drop the input valid and wait until every owed column word has come out,
  // then let any trailing pixel write settle.
  task automatic drain_words();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (planned_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write the layer sequence register; only called while the block is idle.
  task automatic write_layer_sequence(input logic [lmps_pkg::SeqW-1:0] value);
    @(negedge clk);
    cfg_valid_i      <= 1'b1;
    layer_sequence_i <= value;
    do @(posedge clk); while (!cfg_ready_o);
    seq_shadow = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // One random word. Most writes land on the row and plane that the next
  // tick will scan, so the read-back shows them; the rest are noise,
  // off-plane writes among them.
  task automatic random_item();
    int                          pick;
    logic [lmps_pkg::PlaneW-1:0] pl;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_tick();
    end else if (pick < 50) begin
      send_word(lmps_pkg::MODE_WRITE, lmps_pkg::PlaneW'($urandom_range(3)),
                lmps_pkg::RowW'($urandom_range(NRows - 1)),
                lmps_pkg::ColW'($urandom_range(NCols - 1)),
                lmps_pkg::ColourW'($urandom_range(63)));
    end else begin
      pl = ($urandom_range(99) < 70) ? plane_for_slot(seq_shadow, next_slot)
                                     : lmps_pkg::PlaneW'($urandom_range(NPlanes - 1));
      send_word(lmps_pkg::MODE_WRITE, pl, lmps_pkg::RowW'(next_row),
                lmps_pkg::ColW'($urandom_range(NCols - 1)),
                lmps_pkg::ColourW'($urandom_range(63)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // Stall the column words at random, except during a burst.
  always @(negedge clk) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < IdlePct);
  end

  task automatic flag_field(input string field, input int want, input int got);
    $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
    failures++;
  endtask

  // Check every column word taken against the oldest prediction.
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (planned_words.size() == 0) begin
        $display("%0t ns: unexpected column word row %0d col %0d data %0d plane %0d last %0b",
                 $time, row_address_o, column_index_o, data_bits_o, shown_plane_o,
                 latch_last_o);
        failures++;
      end else begin
        head_word = planned_words.pop_front();
        words_checked++;
        if (row_address_o !== head_word.row_address)
          flag_field("row_address", int'(head_word.row_address), int'(row_address_o));
        if (column_index_o !== head_word.column_index)
          flag_field("column_index", int'(head_word.column_index), int'(column_index_o));
        if (data_bits_o !== head_word.data_bits)
          flag_field("data_bits", int'(head_word.data_bits), int'(data_bits_o));
        if (shown_plane_o !== head_word.shown_plane)
          flag_field("shown_plane", int'(head_word.shown_plane), int'(shown_plane_o));
        if (latch_last_o !== head_word.latch_last)
          flag_field("latch_last", int'(head_word.latch_last), int'(latch_last_o));
      end
    end
  end

  // Abandon the run once no handshake of any kind has happened for too long.
  always @(posedge clk) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t ns: no handshake for %0d cycles, %0d column words still owed",
               $time, quiet_cycles, planned_words.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // All codes 3: every slot clamps to the top plane. Write both ends of row 0
  // on that plane, shadow one entry on plane 0, and leave the rest cleared.
  task automatic test_clamped_codes();
    write_layer_sequence({lmps_pkg::SeqW{1'b1}});
    send_word(lmps_pkg::MODE_WRITE, 2'd2, 4'd0, 5'd0, 6'd63);
    send_word(lmps_pkg::MODE_WRITE, 2'd2, 4'd0, 5'd31, 6'd42);
    send_word(lmps_pkg::MODE_WRITE, 2'd0, 4'd0, 5'd0, 6'd21);
    send_tick();
  endtask

  // Writes to the missing plane must leave every real plane untouched.
  task automatic test_offplane_write();
    drain_words();
    write_layer_sequence('0);
    send_word(lmps_pkg::MODE_WRITE, 2'd3, 4'd1, 5'd2, 6'd63);
    send_word(lmps_pkg::MODE_WRITE, 2'd3, 4'd1, 5'd31, 6'd63);
    send_word(lmps_pkg::MODE_WRITE, 2'd1, 4'd1, 5'd4, 6'd7);
    send_tick();
  endtask

  // Tick fields carry nothing: send one with all ones, one with all zeros.
  task automatic test_tick_fields_ignored();
    drain_words();
    write_layer_sequence(lmps_pkg::LAYER_SEQ_RESET);
    send_word(lmps_pkg::MODE_TICK, 2'd3, 4'd15, 5'd31, 6'd63);
    send_word(lmps_pkg::MODE_WRITE, plane_for_slot(seq_shadow, next_slot),
              next_row[lmps_pkg::RowW-1:0], 5'd31, 6'd63);
    send_word(lmps_pkg::MODE_TICK, 2'd0, 4'd0, 5'd0, 6'd0);
  endtask

  // Tick until the scan row wraps back to row 0 and is scanned again; the
  // slot counter wraps on the way.
  task automatic test_row_and_slot_wrap();
    int remaining;
    remaining = NRows - next_row + 1;
    repeat (remaining) send_tick();
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) random_item();
  endtask

  // Hold the sender until every owed word is out, then pick a new weighting.
  task automatic test_sender_pause();
    drain_words();
    write_layer_sequence(lmps_pkg::SeqW'($urandom_range(2**lmps_pkg::SeqW - 1)));
  endtask

  // Back-to-back words with no gaps and no output stalls.
  task automatic test_burst(input int count);
    no_idle = 1'b1;
    test_random_traffic(count);
    no_idle = 1'b0;
  endtask

  initial begin
    for (int p = 0; p < NPlanes; p++)
      for (int r = 0; r < NRows; r++)
        for (int c = 0; c < NCols; c++)
          pixel_shadow[p][r][c] = '0;

    // hold reset, then release it away from the rising edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    test_clamped_codes();
    test_offplane_write();
    test_tick_fields_ignored();
    test_row_and_slot_wrap();
    test_random_traffic(100);
    test_sender_pause();
    test_burst(60);
    test_sender_pause();
    test_random_traffic(96);

    drain_words();
    repeat (TailCycles) @(posedge clk);

    $display("Run covered %0d pixel writes (%0d to the missing plane) and %0d refresh ticks,",
             writes_sent, offplane_sent, ticks_sent);
    $display("%0d column words checked under %0d layer sequence settings",
             words_checked, cfg_writes);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
